[rtl/cse_pkg.sv]
`timescale 1ns / 1ps

package cse_pkg;

   localparam logic MODE_HDR = 1'b0;
   localparam logic MODE_TCP = 1'b1;

   localparam logic [15:0] HDR_CSUM_HI_POS = 16'd10;
   localparam logic [15:0] HDR_CSUM_LO_POS = 16'd11;
   localparam logic [15:0] ADDR_FIRST_POS  = 16'd12;
   localparam logic [15:0] ADDR_LAST_POS   = 16'd19;
   localparam logic [15:0] TOTLEN_HI_POS   = 16'd2;
   localparam logic [15:0] TOTLEN_LO_POS   = 16'd3;
   localparam logic [15:0] POS_MAX         = 16'hFFFF;
   localparam logic [5:0]  MIN_HDR_BYTES   = 6'd20;
   localparam logic [3:0]  MIN_IHL         = 4'd5;
   localparam logic [6:0]  TCP_CSUM_OFS    = 7'd16;
   localparam logic [6:0]  HDR_PATCH_OFS   = 7'd10;
   localparam logic [15:0] PROTO_TCP       = 16'd6;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

   // One classified byte, handed from the front to the back.
   typedef struct packed {
      logic        add_en;
      logic [15:0] word;
      logic        last;
      logic        mode;
      logic [15:0] tail_sum;
      logic [6:0]  patch_offset;
      logic        malformed;
   } queue_entry_type;

   // Ones' complement add of two 16-bit values with end-around carry.
   function automatic logic [15:0] fold_add(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] t;
      t = {1'b0, a} + {1'b0, b};
      return t[15:0] + {15'd0, t[16]};
   endfunction

endpackage

[rtl/cse_req_if.sv]
`timescale 1ns / 1ps

interface cse_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] packet_byte;
   logic       last;

   modport source (output valid, output packet_byte, output last, input ready);
   modport sink (input valid, input packet_byte, input last, output ready);
endinterface

[rtl/cse_rsp_if.sv]
`timescale 1ns / 1ps

interface cse_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] checksum;
   logic [6:0]  patch_offset;
   logic        malformed;

   modport source (output valid, output checksum, output patch_offset, output malformed,
                   input ready);
   modport sink (input valid, input checksum, input patch_offset, input malformed,
                 output ready);
endinterface

[rtl/ipv4_tcp_checksum_engine_unit.sv]
`timescale 1ns / 1ps

// Streaming Internet checksum engine for IPv4 header or TCP segment.
// req_if carries one packet byte per transaction, in wire order, with last
// set on the final byte. rsp_if carries one transaction per packet: the
// ones' complement checksum, the byte offset where it belongs, and a flag
// for a packet that was short or had inconsistent lengths.
// csr_we/csr_wdata write the mode bit (0 header checksum, 1 TCP checksum);
// write it only between packets.
// Throughput is one byte per cycle while the queue is not full: each 16-bit
// word needs one add with end-around carry in the back end. The last byte
// enters the queue when it is taken, and the sum stage then loads the result
// into the output register, which drives rsp_if.
// Reset clears the mode to header checksum, the packet state and the queue.
// When the receiver stalls, the result is held in the output register while
// non-final bytes keep flowing through the queue and sum stage; the queue
// fills and req_if.ready drops only when a second result would have to wait.
module ipv4_tcp_checksum_engine_unit (
   input  logic clock,
   input  logic reset,
   input  logic csr_we,
   input  logic csr_wdata,
   cse_req_if.sink   req_if,
   cse_rsp_if.source rsp_if
);
   import cse_pkg::*;

   logic            push, pop, full, empty;
   queue_entry_type push_entry, head;

   cse_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .in_valid   (req_if.valid),
      .in_ready   (req_if.ready),
      .in_byte    (req_if.packet_byte),
      .in_last    (req_if.last),
      .push       (push),
      .push_entry (push_entry),
      .queue_full (full)
   );

   cse_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (full),
      .pop        (pop),
      .head       (head),
      .empty      (empty)
   );

   cse_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head             (head),
      .empty            (empty),
      .pop              (pop),
      .out_valid        (rsp_if.valid),
      .out_ready        (rsp_if.ready),
      .out_checksum     (rsp_if.checksum),
      .out_patch_offset (rsp_if.patch_offset),
      .out_malformed    (rsp_if.malformed)
   );

endmodule

[rtl/cse_front.sv]
`timescale 1ns / 1ps

module cse_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_we,
   input  logic                     csr_wdata,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  logic [7:0]               in_byte,
   input  logic                     in_last,
   output logic                     push,
   output cse_pkg::queue_entry_type push_entry,
   input  logic                     queue_full
);
   import cse_pkg::*;

   logic        mode_ff;
   logic [15:0] pos_ff, pos_in;
   logic [3:0]  ihl_ff, ihl_in;
   logic [15:0] totlen_ff, totlen_in;
   logic [7:0]  held_ff, held_in;

   logic        accept;
   logic [5:0]  hlen;
   logic [5:0]  seg_start;
   logic        in_hdr, in_addr, in_seg, odd_pos;
   logic [7:0]  val;
   logic [16:0] count;
   logic [15:0] tcp_len;

   assign in_ready = !queue_full;
   assign accept   = in_valid && in_ready;
   assign push     = accept;
   assign odd_pos  = pos_ff[0];
   assign count    = {1'b0, pos_ff} + 17'd1;

   always_comb begin
      ihl_in    = (pos_ff == 16'd0) ? in_byte[3:0] : ihl_ff;
      totlen_in = totlen_ff;
      if (pos_ff == TOTLEN_HI_POS) begin
         totlen_in = {in_byte, 8'h00};
      end else if (pos_ff == TOTLEN_LO_POS) begin
         totlen_in = {totlen_ff[15:8], in_byte};
      end
      hlen      = {ihl_in, 2'b00};
      seg_start = (hlen < MIN_HDR_BYTES) ? MIN_HDR_BYTES : hlen;
      in_hdr    = pos_ff < {10'd0, hlen};
      in_addr   = pos_ff >= ADDR_FIRST_POS && pos_ff <= ADDR_LAST_POS;
      in_seg    = pos_ff >= {10'd0, seg_start} && pos_ff < totlen_in;
      tcp_len   = totlen_in - {10'd0, hlen};

      val = in_byte;
      held_in = held_ff;
      push_entry = '0;
      push_entry.last = in_last;
      push_entry.mode = mode_ff;

      if (mode_ff == MODE_HDR) begin
         if (pos_ff == HDR_CSUM_HI_POS || pos_ff == HDR_CSUM_LO_POS) begin
            val = 8'h00;
         end
         if (in_hdr) begin
            if (!odd_pos) begin
               held_in = val;
            end else begin
               push_entry.add_en = 1'b1;
               push_entry.word   = {held_ff, val};
            end
         end
         push_entry.patch_offset = HDR_PATCH_OFS;
         push_entry.malformed    = ihl_in < MIN_IHL || count < {11'd0, hlen};
      end else begin
         // The TCP checksum field sits 16 bytes into the segment.
         if (in_seg && (pos_ff == {10'd0, hlen} + 16'd16 ||
                        pos_ff == {10'd0, hlen} + 16'd17)) begin
            val = 8'h00;
         end
         if (in_addr || in_seg) begin
            if (!odd_pos) begin
               held_in = val;
               // A segment of odd length ends here: pad with a zero low byte.
               if (in_seg && count == {1'b0, totlen_in}) begin
                  push_entry.add_en = 1'b1;
                  push_entry.word   = {val, 8'h00};
               end
            end else begin
               push_entry.add_en = 1'b1;
               push_entry.word   = {held_ff, val};
            end
         end
         push_entry.tail_sum     = fold_add(PROTO_TCP, tcp_len);
         push_entry.patch_offset = {1'b0, hlen} + TCP_CSUM_OFS;
         push_entry.malformed    = ihl_in < MIN_IHL || totlen_in < {10'd0, hlen} ||
                                   count < {1'b0, totlen_in};
      end

      if (in_last) begin
         pos_in = '0;
      end else if (pos_ff != POS_MAX) begin
         pos_in = pos_ff + 16'd1;
      end else begin
         pos_in = pos_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_HDR;
         pos_ff    <= '0;
         ihl_ff    <= '0;
         totlen_ff <= '0;
         held_ff   <= '0;
      end else begin
         if (csr_we) begin
            mode_ff <= csr_wdata;
         end
         if (accept) begin
            pos_ff <= pos_in;
            if (in_last) begin
               ihl_ff    <= '0;
               totlen_ff <= '0;
               held_ff   <= '0;
            end else begin
               ihl_ff    <= ihl_in;
               totlen_ff <= totlen_in;
               held_ff   <= held_in;
            end
         end
      end
   end

endmodule

[rtl/cse_queue.sv]
`timescale 1ns / 1ps

module cse_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  cse_pkg::queue_entry_type push_entry,
   output logic                     full,
   input  logic                     pop,
   output cse_pkg::queue_entry_type head,
   output logic                     empty
);
   import cse_pkg::*;

   queue_entry_type            mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W:0]       wr_ptr_ff;
   logic [QUEUE_PTR_W:0]       rd_ptr_ff;

   assign empty = wr_ptr_ff == rd_ptr_ff;
   assign full  = wr_ptr_ff[QUEUE_PTR_W] != rd_ptr_ff[QUEUE_PTR_W] &&
                  wr_ptr_ff[QUEUE_PTR_W-1:0] == rd_ptr_ff[QUEUE_PTR_W-1:0];
   assign head  = mem_ff[rd_ptr_ff[QUEUE_PTR_W-1:0]];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff[QUEUE_PTR_W-1:0]] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

endmodule

[rtl/cse_back.sv]
`timescale 1ns / 1ps

module cse_back (
   input  logic                     clock,
   input  logic                     reset,
   input  cse_pkg::queue_entry_type head,
   input  logic                     empty,
   output logic                     pop,
   output logic                     out_valid,
   input  logic                     out_ready,
   output logic [15:0]              out_checksum,
   output logic [6:0]               out_patch_offset,
   output logic                     out_malformed
);
   import cse_pkg::*;

   logic [15:0] sum_ff;
   logic        valid_ff, valid_in;
   logic [15:0] chk_ff;
   logic [6:0]  ofs_ff;
   logic        bad_ff;

   logic [15:0] sum_word;
   logic [15:0] sum_final;
   logic        emit;

   // A final transaction may only leave the queue when the output slot frees up.
   assign pop  = !empty && (!head.last || !valid_ff || out_ready);
   assign emit = pop && head.last;

   always_comb begin
      sum_word  = head.add_en ? fold_add(sum_ff, head.word) : sum_ff;
      sum_final = (head.mode == MODE_TCP) ? fold_add(sum_word, head.tail_sum) : sum_word;
      if (emit) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (pop) begin
            sum_ff <= head.last ? 16'd0 : sum_word;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         chk_ff <= ~sum_final;
         ofs_ff <= head.patch_offset;
         bad_ff <= head.malformed;
      end
   end

   assign out_valid        = valid_ff;
   assign out_checksum     = chk_ff;
   assign out_patch_offset = ofs_ff;
   assign out_malformed    = bad_ff;

endmodule

[test/cse_checksum_checker.sv]
`timescale 1ns / 1ps

module cse_checksum_checker (
   input  logic clock,
   input  logic reset,
   input  logic csr_we,
   input  logic csr_wdata,
   cse_req_if   req_mon,
   cse_rsp_if   rsp_mon,
   output int   fail_count,
   output int   results_due
);
   import cse_pkg::*;

   typedef struct packed {
      logic [15:0] checksum;
      logic [6:0]  patch_offset;
      logic        malformed;
   } csum_result_type;

   csum_result_type checksums_due[$];

   // Shadow of the engine's per-packet state.
   logic        csum_mode;
   logic [15:0] acc_sum;
   logic [15:0] byte_pos;
   logic [3:0]  ihl_nib;
   logic [15:0] tot_len;
   logic [7:0]  hi_byte;

   initial begin
      fail_count  = 0;
      results_due = 0;
   end

   function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] t;
      t = {1'b0, a} + {1'b0, b};
      t = {1'b0, t[15:0]} + {16'd0, t[16]};
      return t[15:0];
   endfunction

   task automatic clear_packet_state();
      acc_sum  = '0;
      byte_pos = '0;
      ihl_nib  = '0;
      tot_len  = '0;
      hi_byte  = '0;
   endtask

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("%0t ns: %s mismatch: got 0x%0h, expected 0x%0h", $time, what, got, want);
      fail_count++;
   endtask

   // Works out the effect of one accepted byte; a last byte yields one result.
   task automatic checksum_byte(input logic [7:0] b, input logic is_last);
      int              pos;
      int              hlen;
      int              seg_start;
      int              count;
      logic            in_addr;
      logic            in_seg;
      logic [7:0]      v;
      logic [15:0]     s;
      logic [15:0]     tcp_len;
      csum_result_type r;
      pos = byte_pos;
      if (pos == 0) ihl_nib = b[3:0];
      if (pos == 2) tot_len = {b, 8'h00};
      if (pos == 3) tot_len[7:0] = b;
      hlen = int'(ihl_nib) * 4;

      if (csum_mode == MODE_HDR) begin
         if (pos < hlen) begin
            v = (pos == 10 || pos == 11) ? 8'h00 : b;
            if (pos % 2 == 0) hi_byte = v;
            else acc_sum = ones_add(acc_sum, {hi_byte, v});
         end
      end else begin
         in_addr = (pos >= 12 && pos <= 19);
         seg_start = (hlen < 20) ? 20 : hlen;
         in_seg = (pos >= seg_start && pos < int'(tot_len));
         v = b;
         if (in_seg && (pos - hlen == 16 || pos - hlen == 17)) v = 8'h00;
         if (in_addr || in_seg) begin
            if (pos % 2 == 0) begin
               hi_byte = v;
               // An odd-length segment gets its last byte padded with zero.
               if (in_seg && pos + 1 == int'(tot_len)) acc_sum = ones_add(acc_sum, {v, 8'h00});
            end else begin
               acc_sum = ones_add(acc_sum, {hi_byte, v});
            end
         end
      end

      if (!is_last) begin
         if (byte_pos != POS_MAX) byte_pos++;
         return;
      end

      count = pos + 1;
      s = acc_sum;
      if (csum_mode == MODE_HDR) begin
         r.malformed = (ihl_nib < MIN_IHL) || (count < hlen);
         r.patch_offset = HDR_PATCH_OFS;
      end else begin
         tcp_len = tot_len - hlen[15:0];
         s = ones_add(s, PROTO_TCP);
         s = ones_add(s, tcp_len);
         r.malformed = (ihl_nib < MIN_IHL) || (int'(tot_len) < hlen) || (count < int'(tot_len));
         r.patch_offset = hlen[6:0] + TCP_CSUM_OFS;
      end
      r.checksum = ~s;
      checksums_due.push_back(r);
      clear_packet_state();
   endtask

   always @(posedge clock) begin
      csum_result_type want;
      if (reset) begin
         clear_packet_state();
         csum_mode = MODE_HDR;
         checksums_due.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (checksums_due.size() == 0) begin
               $display("%0t ns: result transaction with no packet outstanding", $time);
               fail_count++;
            end else begin
               want = checksums_due.pop_front();
               if (rsp_mon.checksum !== want.checksum)
                  report_mismatch("checksum", rsp_mon.checksum, want.checksum);
               if (rsp_mon.patch_offset !== want.patch_offset)
                  report_mismatch("patch_offset", rsp_mon.patch_offset, want.patch_offset);
               if (rsp_mon.malformed !== want.malformed)
                  report_mismatch("malformed", rsp_mon.malformed, want.malformed);
            end
         end
         if (req_mon.valid && req_mon.ready) checksum_byte(req_mon.packet_byte, req_mon.last);
         if (csr_we) csum_mode = csr_wdata;
      end
      results_due = checksums_due.size();
   end

endmodule

[test/ipv4_tcp_checksum_engine_unit_tb.sv]
`timescale 1ns / 1ps

module ipv4_tcp_checksum_engine_unit_tb;
   import cse_pkg::*;

   localparam int FILL_RANDOM = 0;
   localparam int FILL_ZERO   = 1;
   localparam int FILL_ONES   = 2;
   localparam int NUM_PHASES  = 8;

   logic clock     = 1'b0;
   logic reset     = 1'b1;
   logic csr_we    = 1'b0;
   logic csr_wdata = 1'b0;

   int send_idle_pct = 0;
   int stall_pct     = 0;
   int fail_count;
   int results_due;

   logic [7:0] pkt_bytes[$];

   cse_req_if req_chan ();
   cse_rsp_if rsp_chan ();

   ipv4_tcp_checksum_engine_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_if    (req_chan),
      .rsp_if    (rsp_chan)
   );

   cse_checksum_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .req_mon     (req_chan),
      .rsp_mon     (rsp_chan),
      .fail_count  (fail_count),
      .results_due (results_due)
   );

   always #5 clock = ~clock;

   initial begin
      req_chan.valid       = 1'b0;
      req_chan.packet_byte = '0;
      req_chan.last        = 1'b0;
      rsp_chan.ready       = 1'b0;
   end

   always @(negedge clock) begin
      rsp_chan.ready <= ($urandom_range(0, 99) >= stall_pct);
   end

   initial begin
      #50_000_000;
      $display("** ipv4_tcp_checksum_engine_unit: FAILED **");
      $finish;
   end

   // Called at a falling edge; returns at the falling edge after the transaction.
   task automatic push_byte(input logic [7:0] b, input logic is_last);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.packet_byte <= b;
      req_chan.last        <= is_last;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
   endtask

   task automatic send_packet();
      foreach (pkt_bytes[i]) push_byte(pkt_bytes[i], i == pkt_bytes.size() - 1);
   endtask

   // Stops sending and lets every outstanding result drain out.
   task automatic settle();
      req_chan.valid <= 1'b0;
      while (results_due != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_mode(input logic m);
      settle();
      csr_we    <= 1'b1;
      csr_wdata <= m;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic build_packet(input int ihl, input int tot, input int nbytes, input int fill);
      logic [7:0] b;
      pkt_bytes.delete();
      for (int i = 0; i < nbytes; i++) begin
         case (fill)
            FILL_ZERO: b = 8'h00;
            FILL_ONES: b = 8'hFF;
            default:   b = 8'($urandom_range(0, 255));
         endcase
         pkt_bytes.push_back(b);
      end
      if (nbytes > 0) pkt_bytes[0][3:0] = 4'(ihl);
      if (nbytes > 2) pkt_bytes[2] = 8'(tot >> 8);
      if (nbytes > 3) pkt_bytes[3] = 8'(tot);
   endtask

   // Mostly well-formed packets with random content; the rest are broken on purpose.
   task automatic random_packet();
      int kind;
      int ihl;
      int tot;
      kind = $urandom_range(0, 99);
      ihl = ($urandom_range(0, 99) < 70) ? 5 : $urandom_range(5, 15);
      tot = ihl * 4 + $urandom_range(0, 24);
      if (kind < 75) begin
         build_packet(ihl, tot, tot, FILL_RANDOM);
      end else if (kind < 85) begin
         build_packet(ihl, tot, tot + $urandom_range(1, 6), FILL_RANDOM);
      end else if (kind < 92) begin
         build_packet(ihl, tot, $urandom_range(1, tot - 1), FILL_RANDOM);
      end else if (kind < 96) begin
         build_packet($urandom_range(0, 4), $urandom_range(0, 40), $urandom_range(1, 40),
                      FILL_RANDOM);
      end else begin
         build_packet(ihl, $urandom_range(0, ihl * 4 - 1), ihl * 4 + $urandom_range(0, 8),
                      FILL_RANDOM);
      end
   endtask

   task automatic run_directed();
      build_packet(5, 20, 20, FILL_ZERO);        send_packet();
      build_packet(15, 65535, 60, FILL_ONES);    send_packet();
      build_packet(15, 80, 80, FILL_RANDOM);     send_packet();
      build_packet(4, 40, 30, FILL_RANDOM);      send_packet();
      build_packet(5, 25, 25, FILL_RANDOM);      send_packet();
      build_packet(6, 30, 35, FILL_RANDOM);      send_packet();
      build_packet(5, 20, 1, FILL_RANDOM);       send_packet();
      build_packet(7, 10, 28, FILL_RANDOM);      send_packet();
      build_packet(5, 60, 40, FILL_RANDOM);      send_packet();
   endtask

   initial begin
      logic phase_mode[NUM_PHASES] = '{MODE_TCP, MODE_HDR, MODE_TCP, MODE_HDR,
                                      MODE_HDR, MODE_TCP, MODE_HDR, MODE_TCP};
      int   phase_idle[NUM_PHASES] = '{0, 0, 61, 61, 0, 0, 18, 18};
      int   phase_stall[NUM_PHASES] = '{0, 0, 0, 0, 61, 61, 18, 18};
      int   byte_total;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // The mode comes out of reset in header mode.
      run_directed();
      write_mode(MODE_TCP);
      run_directed();

      for (int p = 0; p < NUM_PHASES; p++) begin
         write_mode(phase_mode[p]);
         send_idle_pct = phase_idle[p];
         stall_pct     = phase_stall[p];
         byte_total = 0;
         while (byte_total < 36) begin
            if ($urandom_range(0, 19) == 0) settle();
            random_packet();
            send_packet();
            byte_total += pkt_bytes.size();
         end
      end

      settle();
      if (fail_count == 0) begin
         $display("** ipv4_tcp_checksum_engine_unit: PASSED **");
      end else begin
         $display("** ipv4_tcp_checksum_engine_unit: FAILED **");
      end
      $finish;
   end

endmodule
